>>> sv/rpsb_pkg.sv
// Shared constants, codes and handshake types of the palette sprite blitter.
`timescale 1ns / 1ps
`default_nettype none

package rpsb_pkg;

    // Sprite layout
    localparam int PaletteSize  = 16;
    localparam int HeaderStart  = PaletteSize * 3;
    localparam int RunPhase     = HeaderStart + 4;

    // Field widths
    localparam int PhaseW  = 6;
    localparam int IdxW    = 4;
    localparam int RunW    = 4;
    localparam int ColW    = 9;
    localparam int AddrW   = 20;
    localparam int ColorW  = 16;
    localparam int DimW    = 10;
    localparam int CfgIdxW = 2;
    localparam int OutDataW = 40;

    localparam logic [AddrW-1:0]  AddrMax     = '1;
    localparam logic [PhaseW-1:0] PhaseRun    = PhaseW'(RunPhase);
    localparam logic [DimW-1:0]   WidthReset  = 10'd240;
    localparam logic [DimW-1:0]   HeightReset = 10'd224;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_FRAME_HEIGHT = 2'd1;

    // Position of a byte inside one palette entry
    localparam logic [1:0] PART_RED   = 2'd0;
    localparam logic [1:0] PART_GREEN = 2'd1;
    localparam logic [1:0] PART_BLUE  = 2'd2;

    // Position of a byte inside the header
    localparam logic [1:0] HDR_X0     = 2'd0;
    localparam logic [1:0] HDR_Y0     = 2'd1;
    localparam logic [1:0] HDR_WIDTH  = 2'd2;
    localparam logic [1:0] HDR_HEIGHT = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;      // input beat accepted this cycle
        logic step;      // process one pixel of the current run
        logic last;      // this step is the final pixel of the run
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic            run_phase;  // next byte is a run byte
        logic [RunW-1:0] run_len;    // length nibble of the offered byte
        logic            idx_zero;   // latched run is transparent
        logic            out_free;   // output register can take a beat
    } sts_t;

    // RGB888 to RGB565 packing
    function automatic logic [ColorW-1:0] pack565(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        pack565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

`default_nettype wire

>>> sv/rle_palette_sprite_blitter_unit.sv
// Top level of the run-length palette sprite blitter.
//
// Input stream (s_*): one sprite byte per beat, s_tlast on the final byte of
// a sprite. The first 48 bytes load sixteen RGB888 palette entries, four
// header bytes follow (x0, y0, width, unused height), then run bytes with the
// length in the high nibble and the palette index in the low nibble.
// Output stream (m_*): one beat per framebuffer write, s_tlast-like m_tlast
// on the last write of a run byte. Index zero writes nothing.
// Configuration channel (cfg_*): frame width (index 0) and frame height
// (index 1), always ready; write only while the block is idle.
// Sequencing: palette and header bytes are accepted in the idle state. A run byte
// is accepted in the idle state, then the controller steps through its pixels;
// each step with a nonzero index loads one write into the output register. A
// single pixel address unit produces one address per cycle while the run is not stalled.
// Stalls: while m_tready is low the output register holds its beat and a run with
// a nonzero index pauses; a waiting beat does not block the next input byte.
// Reset: the palette is undefined, the header state clears, the frame size
// returns to 240 by 224 and the next byte starts a new palette.
`timescale 1ns / 1ps
`default_nettype none

module rle_palette_sprite_blitter_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] sprite_byte
    input  wire logic                          s_tlast,   // final_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [19:0] pixel_address, [35:20] pixel_color, [36] outside_frame, [39:37] zero
    output logic [rpsb_pkg::OutDataW-1:0]      m_tdata,
    output logic                               m_tlast,   // run_last
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [rpsb_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [rpsb_pkg::DimW-1:0]     cfg_data
);
    import rpsb_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    // Sequencer
    rpsb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath
    rpsb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

>>> sv/rpsb_ctrl.sv
// Controller state machine: byte acceptance and run pixel sequencing.
`timescale 1ns / 1ps
`default_nettype none

module rpsb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  rpsb_pkg::sts_t     sts,
    output rpsb_pkg::cmd_t     cmd
);
    import rpsb_pkg::*;

    state_t          state_reg, state_next;
    logic [RunW-1:0] cnt_reg, cnt_next;

    // State and run counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
                if (s_tvalid && sts.run_phase && (sts.run_len != '0))
                begin
                    state_next = ST_RUN;
                    cnt_next   = sts.run_len;
                end
            end
            ST_RUN:
            begin
                // A transparent pixel needs no output slot.
                cmd.step = sts.idx_zero || sts.out_free;
                cmd.last = (cnt_reg == RunW'(1));
                if (cmd.step)
                begin
                    cnt_next = cnt_reg - RunW'(1);
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/rpsb_datapath.sv
// Datapath: palette, header state, pixel address generation and output register.
`timescale 1ns / 1ps
`default_nettype none

module rpsb_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          s_tlast,
    input  wire logic                          cfg_valid,
    input  wire logic [rpsb_pkg::CfgIdxW-1:0]  cfg_index,
    input  wire logic [rpsb_pkg::DimW-1:0]     cfg_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [rpsb_pkg::OutDataW-1:0]      m_tdata,
    output logic                               m_tlast,
    input  rpsb_pkg::cmd_t                     cmd,
    output rpsb_pkg::sts_t                     sts
);
    import rpsb_pkg::*;

    // Configuration
    logic [DimW-1:0]   fw_reg, fh_reg;
    logic [AddrW-1:0]  limit_reg;

    // Sprite state
    logic [PhaseW-1:0] phase_reg;
    logic [1:0]        part_reg;
    logic [IdxW-1:0]   entry_reg;
    logic [15:0]       rg_reg;
    logic [ColorW-1:0] palette_reg [PaletteSize];
    logic [7:0]        x0_reg, sw_reg;
    logic [ColW-1:0]   col_reg;
    logic [AddrW-1:0]  rb_reg;
    logic [IdxW-1:0]   idx_reg;

    // Output register
    logic                valid_reg;
    logic [AddrW-1:0]    addr_reg;
    logic [ColorW-1:0]   color_reg;
    logic                outside_reg;
    logic                last_reg;

    logic              in_palette, in_header;
    logic [17:0]       y_prod;
    logic              wrap;
    logic [ColW-1:0]   col_w;
    logic [AddrW:0]    rb_sum, addr_sum;
    logic [AddrW-1:0]  rb_w, addr_w;

    assign in_palette = (phase_reg[5:4] != 2'b11);
    assign in_header  = !in_palette && (phase_reg < PhaseRun);
    assign y_prod     = 18'(s_tdata) * 18'(fw_reg);

    // Pixel step: wrap the column, then form the saturated address
    always_comb
    begin
        wrap   = (col_reg >= {1'b0, sw_reg});
        col_w  = wrap ? (col_reg - {1'b0, sw_reg}) : col_reg;
        rb_sum = {1'b0, rb_reg} + (AddrW + 1)'(fw_reg);
        if (!wrap)
        begin
            rb_w = rb_reg;
        end
        else if (rb_sum[AddrW])
        begin
            rb_w = AddrMax;
        end
        else
        begin
            rb_w = rb_sum[AddrW-1:0];
        end
        addr_sum = {1'b0, rb_w} + (AddrW + 1)'(col_w);
        addr_w   = addr_sum[AddrW] ? AddrMax : addr_sum[AddrW-1:0];
    end

    // Configuration registers and the frame size product
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= WidthReset;
            fh_reg    <= HeightReset;
            limit_reg <= AddrW'(WidthReset) * AddrW'(HeightReset);
        end
        else
        begin
            if (cfg_valid && (cfg_index == REG_FRAME_WIDTH))
            begin
                fw_reg <= cfg_data;
            end
            if (cfg_valid && (cfg_index == REG_FRAME_HEIGHT))
            begin
                fh_reg <= cfg_data;
            end
            limit_reg <= AddrW'(fw_reg) * AddrW'(fh_reg);
        end
    end

    // Byte phase tracking and header/run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            part_reg  <= PART_RED;
            entry_reg <= '0;
            rg_reg    <= '0;
            x0_reg    <= '0;
            sw_reg    <= '0;
            col_reg   <= '0;
            rb_reg    <= '0;
            idx_reg   <= '0;
        end
        else if (cmd.take)
        begin
            if (in_palette)
            begin
                case (part_reg)
                    PART_RED:   rg_reg[15:8] <= s_tdata;
                    PART_GREEN: rg_reg[7:0]  <= s_tdata;
                    default:    rg_reg       <= rg_reg;
                endcase
            end
            else if (in_header)
            begin
                case (phase_reg[1:0])
                    HDR_X0:    x0_reg  <= s_tdata;
                    HDR_Y0:    rb_reg  <= AddrW'(y_prod) + AddrW'(x0_reg);
                    HDR_WIDTH: sw_reg  <= s_tdata;
                    default:   col_reg <= '0;
                endcase
            end
            else
            begin
                idx_reg <= s_tdata[IdxW-1:0];
            end
            // A final byte restarts the sprite with a new palette.
            if (s_tlast)
            begin
                phase_reg <= '0;
                part_reg  <= PART_RED;
                entry_reg <= '0;
            end
            else if (in_palette)
            begin
                part_reg  <= (part_reg == PART_BLUE) ? PART_RED : part_reg + 2'd1;
                phase_reg <= phase_reg + PhaseW'(1);
                if (part_reg == PART_BLUE)
                begin
                    entry_reg <= entry_reg + IdxW'(1);
                end
            end
            else if (in_header)
            begin
                phase_reg <= phase_reg + PhaseW'(1);
            end
        end
        else if (cmd.step)
        begin
            col_reg <= col_w + ColW'(1);
            rb_reg  <= rb_w;
        end
    end

    // Palette entries are written on the blue byte
    always_ff @(posedge clk)
    begin
        if (cmd.take && in_palette && (part_reg == PART_BLUE))
        begin
            palette_reg[entry_reg] <= pack565(rg_reg[15:8], rg_reg[7:0], s_tdata);
        end
    end

    // Output register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (cmd.step && (idx_reg != '0))
        begin
            valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.step && (idx_reg != '0))
        begin
            addr_reg    <= addr_w;
            color_reg   <= palette_reg[idx_reg];
            outside_reg <= (addr_w >= limit_reg);
            last_reg    <= cmd.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, outside_reg, color_reg, addr_reg};
    assign m_tlast  = last_reg;

    assign sts.run_phase = (phase_reg == PhaseRun);
    assign sts.run_len   = s_tdata[7:4];
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.out_free  = !valid_reg || m_tready;

endmodule

`default_nettype wire

>>> sv/rpsb_checker.sv
// Port-level checker of the sprite blitter and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rpsb_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [7:0]                    s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [rpsb_pkg::OutDataW-1:0] m_tdata,
    input  wire logic                          m_tlast
);
    import rpsb_pkg::*;

    // A stalled output beat stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output beat dropped while stalled");

    // A stalled output beat keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output payload changed while stalled");

    // A byte that expands to no pixels leaves the input ready.
    a_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tdata[7:4] == 4'd0) |=> s_tready)
        else $error("input blocked after a byte with no pixels");

    // A saturated address always lies outside the frame.
    a_sat_outside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[AddrW-1:0] == AddrMax) |-> m_tdata[AddrW+ColorW])
        else $error("saturated address not flagged outside");

endmodule

bind rle_palette_sprite_blitter_unit rpsb_checker u_rpsb_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the run-length palette sprite blitter.
`timescale 1ns / 1ps

module tb_top;
    import rpsb_pkg::*;

    // One sprite byte as it travels on the input stream
    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } sprite_beat_t;

    // One framebuffer write as it should leave the block
    typedef struct packed {
        logic [AddrW-1:0]  addr;
        logic [ColorW-1:0] color;
        logic              outside;
        logic              last;
    } pixel_write_t;

    // Register index that the block must ignore
    localparam logic [CfgIdxW-1:0] REG_SPARE = 2'd3;
    localparam int SettleCycles = 40;
    localparam int MaxWait = 13;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;       // [7:0] sprite_byte
    logic s_tlast = 1'b0;           // final_byte
    logic m_tvalid;
    logic m_tready = 1'b0;
    // [19:0] pixel_address, [35:20] pixel_color, [36] outside_frame, [39:37] zero
    logic [OutDataW-1:0] m_tdata;
    logic m_tlast;                  // run_last
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [DimW-1:0] cfg_data = '0;

    // Decoder state mirrored by the testbench
    logic [DimW-1:0]   frame_w = WidthReset;
    logic [DimW-1:0]   frame_h = HeightReset;
    logic [PhaseW-1:0] phase = '0;
    logic [ColorW-1:0] palette [PaletteSize];
    logic [15:0]       rg_hold = '0;
    logic [7:0]        org_x = '0;
    logic [7:0]        spr_w = '0;
    logic [ColW-1:0]   col = '0;
    logic [AddrW-1:0]  row_base = '0;

    sprite_beat_t byte_q [$];
    pixel_write_t pixel_writes_due [$];
    sprite_beat_t in_beat;
    pixel_write_t due;

    int bytes_fed = 0;
    int bytes_taken = 0;
    int runs_queued = 0;
    int writes_seen = 0;
    int outside_seen = 0;
    int frame_sizes = 1;
    int mismatches = 0;
    int in_gap = 0;
    int out_wait = 0;
    bit in_taken = 1'b0;
    bit cfg_taken = 1'b0;
    bit steady_in = 1'b0;
    bit steady_out = 1'b0;

    rle_palette_sprite_blitter_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Addresses stick at the top of the 20-bit range.
    function automatic logic [AddrW-1:0] clamp_add(input int unsigned a, input int unsigned b);
        int unsigned s;
        s = a + b;
        return (s > AddrMax) ? AddrMax : s[AddrW-1:0];
    endfunction

    // Advance the mirrored decoder by one byte and queue the writes it causes.
    function automatic void decode_sprite_byte(input logic [7:0] b, input logic fin);
        int unsigned lim;
        int hdr;
        int k;
        logic [3:0] idx;
        logic [3:0] len;
        logic [7:0] r;
        logic [7:0] g;
        pixel_write_t held;
        bit have_held;
        have_held = 1'b0;
        if (phase < HeaderStart)
        begin
            if ((phase % 3) == PART_RED)
                rg_hold[15:8] = b;
            else if ((phase % 3) == PART_GREEN)
                rg_hold[7:0] = b;
            else
            begin
                r = rg_hold[15:8];
                g = rg_hold[7:0];
                palette[phase / 3] = {r[7:3], g[7:2], b[7:3]};
            end
            phase++;
        end
        else if (phase < RunPhase)
        begin
            hdr = phase - HeaderStart;
            if (hdr == HDR_X0)
                org_x = b;
            else if (hdr == HDR_Y0)
                row_base = clamp_add(32'(b) * 32'(frame_w), 32'(org_x));
            else if (hdr == HDR_WIDTH)
                spr_w = b;
            else
                col = '0;
            phase++;
        end
        else
        begin
            idx = b[3:0];
            len = b[7:4];
            lim = 32'(frame_w) * 32'(frame_h);
            for (k = 0; k < len; k++)
            begin
                // Wrap the column first; a zero width wraps on every pixel.
                if (col >= spr_w)
                begin
                    col = col - spr_w;
                    row_base = clamp_add(32'(row_base), 32'(frame_w));
                end
                if (idx != 4'd0)
                begin
                    if (have_held)
                        pixel_writes_due.push_back(held);
                    held.addr = clamp_add(32'(row_base), 32'(col));
                    held.color = palette[idx];
                    held.outside = (32'(held.addr) >= lim);
                    held.last = 1'b0;
                    have_held = 1'b1;
                end
                col = col + 1'b1;
            end
            if (have_held)
            begin
                held.last = 1'b1;
                pixel_writes_due.push_back(held);
            end
        end
        if (fin)
            phase = '0;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    // Predict on every accepted input beat and follow register writes.
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            decode_sprite_byte(s_tdata, s_tlast);
            bytes_taken++;
            in_taken = 1'b1;
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_FRAME_WIDTH)
                frame_w = cfg_data;
            else if (cfg_index == REG_FRAME_HEIGHT)
                frame_h = cfg_data;
            cfg_taken = 1'b1;
        end
    end

    // Input driver: holds a beat until taken, then waits a drawn gap.
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!(s_tvalid && !in_taken))
        begin
            in_taken = 1'b0;
            if (in_gap > 0)
            begin
                in_gap--;
                s_tvalid <= 1'b0;
            end
            else if (byte_q.size() > 0)
            begin
                in_beat = byte_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= in_beat.data;
                s_tlast <= in_beat.fin;
                in_gap = steady_in ? 0 : $urandom_range(0, MaxWait);
                if ($urandom_range(0, 15) == 0)
                    steady_in = !steady_in;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Output stall: ready drops for a drawn number of cycles after each beat.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (out_wait > 0)
        begin
            out_wait--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: every output beat is checked against the oldest predicted write.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            writes_seen++;
            if (pixel_writes_due.size() == 0)
                flag_mismatch($sformatf("write to %0h with none predicted", m_tdata[AddrW-1:0]));
            else
            begin
                due = pixel_writes_due.pop_front();
                if (due.outside)
                    outside_seen++;
                if (m_tdata[AddrW-1:0] !== due.addr)
                    flag_mismatch($sformatf("address %0h, predicted %0h",
                                            m_tdata[AddrW-1:0], due.addr));
                if (m_tdata[AddrW +: ColorW] !== due.color)
                    flag_mismatch($sformatf("color %0h at %0h, predicted %0h",
                                            m_tdata[AddrW +: ColorW], due.addr, due.color));
                if (m_tdata[AddrW+ColorW] !== due.outside)
                    flag_mismatch($sformatf("outside flag %b at %0h, predicted %b",
                                            m_tdata[AddrW+ColorW], due.addr, due.outside));
                if (m_tlast !== due.last)
                    flag_mismatch($sformatf("last flag %b at %0h, predicted %b",
                                            m_tlast, due.addr, due.last));
                if (m_tdata[OutDataW-1:AddrW+ColorW+1] !== '0)
                    flag_mismatch($sformatf("nonzero pad bits at %0h", due.addr));
            end
            out_wait = steady_out ? 0 : $urandom_range(0, MaxWait);
            if ($urandom_range(0, 15) == 0)
                steady_out = !steady_out;
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic fin);
        sprite_beat_t beat;
        beat.data = data;
        beat.fin = fin;
        byte_q.push_back(beat);
        bytes_fed++;
    endtask

    task automatic queue_random_palette();
        int i;
        for (i = 0; i < HeaderStart; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Mostly whole sprites with random content; some are cut short.
    task automatic queue_random_sprite();
        int runs;
        int total;
        int cut;
        int i;
        logic [7:0] data;
        logic fin;
        runs = $urandom_range(6, 20);
        total = RunPhase + runs;
        cut = ($urandom_range(0, 4) == 0) ? $urandom_range(1, RunPhase - 1) : total;
        for (i = 0; i < cut; i++)
        begin
            if (i == HeaderStart + HDR_WIDTH)
                data = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 6))
                                                   : 8'($urandom_range(0, 255));
            else if (i >= RunPhase && $urandom_range(0, 7) == 0)
                data = {4'($urandom_range(0, 15)), 4'h0};
            else
                data = 8'($urandom_range(0, 255));
            fin = (i == cut - 1) && (cut < total || $urandom_range(0, 7) != 0);
            push_byte(data, fin);
            if (i >= RunPhase)
                runs_queued++;
        end
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DimW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_taken = 1'b0;
        @(negedge clk);
        while (!cfg_taken)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_frame(input logic [DimW-1:0] w, input logic [DimW-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        frame_sizes++;
    endtask

    // Wait until every byte is taken and every write has come back, then
    // give a transparent run time to finish inside the block.
    task automatic wait_idle();
        while (bytes_taken != bytes_fed || pixel_writes_due.size() != 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    function automatic logic [DimW-1:0] random_dim();
        case ($urandom_range(0, 3))
            0: return 10'($urandom_range(1, 16));
            1: return 10'd1023;
            default: return 10'($urandom_range(1, 1023));
        endcase
    endfunction

    initial
    begin
        int i;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] bl;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Known palette with black, white, pure primaries and dropped low bits.
        for (i = 0; i < PaletteSize; i++)
        begin
            case (i)
                0: begin r = 8'h00; g = 8'h00; bl = 8'h00; end
                1: begin r = 8'hFF; g = 8'hFF; bl = 8'hFF; end
                2: begin r = 8'hF8; g = 8'h00; bl = 8'h00; end
                3: begin r = 8'h00; g = 8'hFC; bl = 8'h00; end
                4: begin r = 8'h00; g = 8'h00; bl = 8'hF8; end
                5: begin r = 8'h07; g = 8'h03; bl = 8'h07; end
                default:
                begin
                    r = 8'(i * 16 + 1);
                    g = 8'(255 - i * 15);
                    bl = 8'(i * 9);
                end
            endcase
            push_byte(r, 1'b0);
            push_byte(g, 1'b0);
            push_byte(bl, 1'b0);
        end
        // Sprite at the right edge of the default frame, running over its bottom.
        push_byte(8'd200, 1'b0);
        push_byte(8'd220, 1'b0);
        push_byte(8'd40, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hF1, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'h50, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFE, 1'b0);
        push_byte(8'h12, 1'b0);
        repeat (10) push_byte(8'hF0, 1'b0);
        push_byte(8'h37, 1'b0);
        push_byte(8'hF3, 1'b1);
        wait_idle();

        // Largest frame: sprites cut inside the palette and the header, then a
        // zero-width sprite that walks the address into saturation.
        write_frame(10'd1023, 10'd1023);
        for (i = 0; i < 10; i++)
            push_byte(8'($urandom_range(0, 255)), i == 9);
        for (i = 0; i < HeaderStart + 2; i++)
            push_byte(8'($urandom_range(0, 255)), i == HeaderStart + 1);
        queue_random_palette();
        push_byte(8'd255, 1'b0);
        push_byte(8'd255, 1'b0);
        push_byte(8'd0, 1'b0);
        push_byte(8'd0, 1'b0);
        repeat (60) push_byte(8'hF0, 1'b0);
        push_byte(8'hF9, 1'b0);
        push_byte(8'h1A, 1'b1);
        // Sprite that ends right on its height byte.
        queue_random_palette();
        for (i = 0; i < 4; i++)
            push_byte(8'($urandom_range(0, 255)), i == 3);
        wait_idle();

        // Smallest frame, and a write to an unused index that must change nothing.
        write_frame(10'd1, 10'd1);
        write_reg(REG_SPARE, 10'h3FF);
        queue_random_sprite();
        wait_idle();

        // Zero frame width, then zero frame height: everything lies outside.
        write_frame(10'd0, 10'd7);
        queue_random_sprite();
        wait_idle();
        write_frame(random_dim(), 10'd0);
        queue_random_sprite();
        wait_idle();

        // Random frame sizes and random sprites.
        while (runs_queued < 100)
        begin
            write_frame(random_dim(), random_dim());
            repeat ($urandom_range(1, 3)) queue_random_sprite();
            wait_idle();
        end

        $display("Run covered %0d sprite bytes over %0d frame sizes.", bytes_taken, frame_sizes);
        $display("Checked %0d pixel writes, %0d of them outside the frame.",
                 writes_seen, outside_seen);
        if (mismatches == 0)
            $display("rle_palette_sprite_blitter_unit verification clean");
        else
            $display("rle_palette_sprite_blitter_unit verification failed");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #6000000;
        $display("rle_palette_sprite_blitter_unit verification failed");
        $finish;
    end

endmodule
